@@ rtl/core/spc2d_pkg.sv @@
// ----------------------------------------------------------------------------
// spc2d_pkg
// Shared constants and types for the strided, padded 2-D convolution block.
// ----------------------------------------------------------------------------
package spc2d_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned KDIM_W     = 2;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned STEP_MAX   = 8;
  localparam int unsigned WIN_TAPS   = 9;
  localparam int unsigned MAX_RES    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_ROWS = 3'd0,
    REG_KERNEL_COLS = 3'd1,
    REG_STEP_SIZE   = 3'd2,
    REG_PAD_ENABLE  = 3'd3,
    REG_IMAGE_COLS  = 3'd4,
    REG_IMAGE_ROWS  = 3'd5,
    REG_TAPS_FIRST  = 3'd6,
    REG_TAPS_SECOND = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [KDIM_W-1:0] kh;
    logic [KDIM_W-1:0] kw;
    logic [STEP_W-1:0] step;
    logic              pad;
  } geom_t;

  typedef logic [WIN_TAPS-1:0][PIX_W-1:0] window_t;

endpackage

@@ rtl/core/spc2d_if.sv @@
// ----------------------------------------------------------------------------
// spc2d interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface spc2d_pix_if;
  logic                          valid;
  logic                          ready;
  logic [spc2d_pkg::PIX_W-1:0]   pixel;
  logic                          frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface spc2d_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [spc2d_pkg::SUM_W-1:0] sum_value;
  logic [spc2d_pkg::ROW_W-1:0]        out_row;
  logic [spc2d_pkg::COL_W-1:0]        out_col;
  logic                               run_last;
  logic                               frame_done;

  modport source (output valid, output sum_value, output out_row, output out_col,
                  output run_last, output frame_done, input ready);
  modport sink (input valid, input sum_value, input out_row, input out_col,
                input run_last, input frame_done, output ready);
endinterface

interface spc2d_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [spc2d_pkg::CFG_IDX_W-1:0]    index;
  logic [spc2d_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/spc2d_result_gen.sv @@
// ----------------------------------------------------------------------------
// spc2d_result_gen
// Queues finished windows, walks the output positions each one closes and
// computes the weighted sum for each position.
// ----------------------------------------------------------------------------
module spc2d_result_gen #(
  parameter int P_W       = 15,
  parameter int COEF_BITS = 12,
  parameter int DEPTH     = 8
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  spc2d_pkg::geom_t                              geom_i,
  input  logic [P_W-1:0]                                rows_i,
  input  logic [P_W-1:0]                                cols_i,
  input  logic [spc2d_pkg::WIN_TAPS-1:0][COEF_BITS-1:0] coef_i,
  input  logic                                          push_i,
  input  spc2d_pkg::window_t                            push_win_i,
  input  logic [P_W-1:0]                                push_rf_i,
  input  logic [P_W-1:0]                                push_rl_i,
  input  logic [P_W-1:0]                                push_cf_i,
  input  logic [P_W-1:0]                                push_cl_i,
  input  logic [P_W-1:0]                                push_ir_i,
  input  logic [P_W-1:0]                                push_ic_i,
  input  logic                                          push_have_i,
  input  logic                                          push_end_i,
  output logic [$clog2(DEPTH+1)-1:0]                    fill_o,
  spc2d_res_if.source                                   res_o
);

  localparam int PT_W  = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int SW    = P_W + 6;
  localparam int PR_W  = spc2d_pkg::PIX_W + COEF_BITS + 1;
  localparam int AC_W  = PR_W + 4;
  localparam int N_W   = $clog2(spc2d_pkg::MAX_RES);

  spc2d_pkg::window_t q_win [DEPTH];
  logic [P_W-1:0]     q_rf [DEPTH];
  logic [P_W-1:0]     q_rl [DEPTH];
  logic [P_W-1:0]     q_cf [DEPTH];
  logic [P_W-1:0]     q_cl [DEPTH];
  logic [P_W-1:0]     q_ir [DEPTH];
  logic [P_W-1:0]     q_ic [DEPTH];
  logic               q_have [DEPTH];
  logic               q_end [DEPTH];

  logic [PT_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             empty, pop, adv;

  logic [P_W-1:0] gr_q, gr_d, gc_q, gc_d;
  logic [N_W-1:0] gn_q, gn_d;
  logic           busy_q, busy_d;
  logic [P_W-1:0] cur_r, cur_c;
  logic [N_W-1:0] cur_n;
  logic           at_last;
  logic [P_W+3:0] rs, cs;

  logic                  g_v_q;
  logic signed [SW-1:0]  g_y0_q, g_oy_q, g_x0_q, g_ox_q;
  logic [SW-1:0]         y0_d, oy_d, x0_d, ox_d;
  logic [P_W-1:0]        g_r_q, g_c_q;
  logic                  g_last_q, g_done_q;
  spc2d_pkg::window_t    g_win_q;

  logic signed [SW-1:0]  rows_s, cols_s;
  logic signed [PR_W-1:0] prod_d [spc2d_pkg::WIN_TAPS];
  logic signed [PR_W-1:0] p_prod_q [spc2d_pkg::WIN_TAPS];
  logic                   p_v_q;
  logic [P_W-1:0]         p_r_q, p_c_q;
  logic                   p_last_q, p_done_q;

  logic signed [AC_W-1:0]             acc;
  logic                               res_v_q;
  logic signed [spc2d_pkg::SUM_W-1:0] sum_q;
  logic [spc2d_pkg::ROW_W-1:0]        row_q;
  logic [spc2d_pkg::COL_W-1:0]        col_q;
  logic                               last_q, done_q;

  assign empty  = (cnt_q == '0);
  assign adv    = !res_v_q || res_o.ready;
  assign fill_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_win[wr_ptr_q]  <= push_win_i;
      q_rf[wr_ptr_q]   <= push_rf_i;
      q_rl[wr_ptr_q]   <= push_rl_i;
      q_cf[wr_ptr_q]   <= push_cf_i;
      q_cl[wr_ptr_q]   <= push_cl_i;
      q_ir[wr_ptr_q]   <= push_ir_i;
      q_ic[wr_ptr_q]   <= push_ic_i;
      q_have[wr_ptr_q] <= push_have_i;
      q_end[wr_ptr_q]  <= push_end_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_comb begin
    cur_r   = busy_q ? gr_q : q_rf[rd_ptr_q];
    cur_c   = busy_q ? gc_q : q_cf[rd_ptr_q];
    cur_n   = busy_q ? gn_q : '0;
    at_last = ((cur_r == q_rl[rd_ptr_q]) && (cur_c == q_cl[rd_ptr_q])) ||
              (cur_n == N_W'(spc2d_pkg::MAX_RES - 1));
    pop     = adv && !empty && (!q_have[rd_ptr_q] || at_last);
    busy_d  = busy_q;
    gr_d    = gr_q;
    gc_d    = gc_q;
    gn_d    = gn_q;
    if (adv && !empty) begin
      if (pop) begin
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
        gn_d   = cur_n + 1'b1;
        if (cur_c == q_cl[rd_ptr_q]) begin
          gc_d = q_cf[rd_ptr_q];
          gr_d = cur_r + 1'b1;
        end else begin
          gc_d = cur_c + 1'b1;
          gr_d = cur_r;
        end
      end
    end
  end

  assign rs   = cur_r * geom_i.step;
  assign cs   = cur_c * geom_i.step;
  assign y0_d = SW'(rs) - SW'(geom_i.pad);
  assign x0_d = SW'(cs) - SW'(geom_i.pad);
  assign oy_d = y0_d - SW'(q_ir[rd_ptr_q]) + SW'(2);
  assign ox_d = x0_d - SW'(q_ic[rd_ptr_q]) + SW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      gr_q     <= '0;
      gc_q     <= '0;
      gn_q     <= '0;
      g_v_q    <= 1'b0;
      p_v_q    <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      gr_q   <= gr_d;
      gc_q   <= gc_d;
      gn_q   <= gn_d;
      if (adv) begin
        g_v_q   <= !empty && q_have[rd_ptr_q];
        p_v_q   <= g_v_q;
        res_v_q <= p_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_y0_q   <= y0_d;
      g_oy_q   <= oy_d;
      g_x0_q   <= x0_d;
      g_ox_q   <= ox_d;
      g_r_q    <= cur_r;
      g_c_q    <= cur_c;
      g_last_q <= at_last;
      g_done_q <= at_last && q_end[rd_ptr_q];
      g_win_q  <= q_win[rd_ptr_q];
      p_prod_q <= prod_d;
      p_r_q    <= g_r_q;
      p_c_q    <= g_c_q;
      p_last_q <= g_last_q;
      p_done_q <= g_done_q;
      sum_q    <= spc2d_pkg::SUM_W'(acc);
      row_q    <= spc2d_pkg::ROW_W'(p_r_q);
      col_q    <= spc2d_pkg::COL_W'(p_c_q);
      last_q   <= p_last_q;
      done_q   <= p_done_q;
    end
  end

  assign rows_s = SW'(rows_i);
  assign cols_s = SW'(cols_i);

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      logic signed [SW-1:0]        y, x, dy, dx;
      logic                        ok;
      logic [3:0]                  sel, tsel;
      logic [spc2d_pkg::PIX_W-1:0] pix;
      logic signed [COEF_BITS-1:0] tv;

      assign y    = g_y0_q + SW'(gi);
      assign x    = g_x0_q + SW'(gj);
      assign dy   = g_oy_q + SW'(gi);
      assign dx   = g_ox_q + SW'(gj);
      assign ok   = (gi < geom_i.kh) && (gj < geom_i.kw) &&
                    (y >= 0) && (y < rows_s) && (x >= 0) && (x < cols_s) &&
                    (dy >= 0) && (dy <= 2) && (dx >= 0) && (dx <= 2);
      assign sel  = 4'(dy[1:0]) * 4'd3 + 4'(dx[1:0]);
      assign tsel = 4'(gi) * 4'(geom_i.kw) + 4'(gj);
      assign pix  = ok ? g_win_q[sel] : '0;
      assign tv   = ok ? coef_i[tsel] : '0;
      assign prod_d[gi*3+gj] = $signed({1'b0, pix}) * tv;
    end
  end

  always_comb begin
    acc = '0;
    for (int l = 0; l < spc2d_pkg::WIN_TAPS; l++) begin
      acc = acc + AC_W'(p_prod_q[l]);
    end
  end

  assign res_o.valid      = res_v_q;
  assign res_o.sum_value  = sum_q;
  assign res_o.out_row    = row_q;
  assign res_o.out_col    = col_q;
  assign res_o.run_last   = last_q;
  assign res_o.frame_done = done_q;

endmodule

@@ rtl/core/strided_padded_convolution_2d_top.sv @@
// Throughput: one pixel per cycle while the 8-entry window queue has room,
// one result per cycle while the result channel is ready; a pixel that closes
// n windows holds the result generator while it issues its n results.
// Reset clears position, window, configuration and all valid flags; the line
// memory is not cleared, and only entries written since reset feed a result.
// ----------------------------------------------------------------------------
// strided_padded_convolution_2d_top
// Streaming 2-D convolution on a stride grid with an optional zero border.
// ----------------------------------------------------------------------------
module strided_padded_convolution_2d_top #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 4096,
  parameter int KERNEL_MAX = 3,
  parameter int COEF_BITS  = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spc2d_pix_if.sink  pix_i,
  spc2d_res_if.source res_o,
  spc2d_cfg_if.sink  cfg_i
);

  localparam int CA_W  = $clog2(MAX_COLS);
  localparam int RA_W  = $clog2(MAX_ROWS);
  localparam int AX    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int P_W   = $clog2(AX + 16);
  localparam int K_SH  = P_W + 3;
  localparam int RC_W  = K_SH + 1;
  localparam int DEPTH = 8;
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int TW    = spc2d_pkg::WIN_TAPS;

  typedef struct packed {
    logic           ok;
    logic [P_W-1:0] nf;
    logic [P_W-1:0] nl;
  } span_t;

  logic [1:0]  kernel_rows_q, kernel_cols_q;
  logic [3:0]  step_size_q;
  logic        pad_enable_q;
  logic [10:0] image_cols_q;
  logic [12:0] image_rows_q;
  logic [59:0] taps_first_q;
  logic [47:0] taps_second_q;

  spc2d_pkg::geom_t geom;
  logic [P_W-1:0]   rows_p, cols_p;
  logic [TW-1:0][COEF_BITS-1:0] coef;

  logic [RA_W-1:0] row_cnt_q, row_cnt_d;
  logic [CA_W-1:0] col_cnt_q, col_cnt_d;
  logic [RA_W:0]   r_t, r_n;
  logic [CA_W:0]   c_t, c_n;
  logic [RA_W-1:0] ir;
  logic [CA_W-1:0] ic;
  logic            acc;

  logic [15:0] line_mem [MAX_COLS];
  logic [15:0] rd_q, last_wr_q, word, wr_word;

  logic                        s1_v_q, s1_fwd_q;
  logic [spc2d_pkg::PIX_W-1:0] s1_px_q;
  logic [RA_W-1:0]             s1_ir_q;
  logic [CA_W-1:0]             s1_ic_q;
  logic [spc2d_pkg::PIX_W-1:0] top_px, mid_px;
  spc2d_pkg::window_t          win_q, win_d;

  logic               s2_v_q, s2_end_q;
  spc2d_pkg::window_t s2_win_q;
  logic [P_W-1:0]     s2_ir_q, s2_ic_q;
  span_t              s2_rs_q, s2_cs_q, rsp, csp;
  logic [RC_W-1:0]    rcp;
  logic [P_W+RC_W-1:0] mrf, mrl, mcf, mcl;
  logic [P_W-1:0]     rf, rl, cf, cl;
  logic               have;

  logic [CNT_W-1:0] fill;
  logic [CNT_W:0]   inflight;

  function automatic logic [RC_W-1:0] recip(input logic [spc2d_pkg::STEP_W-1:0] s);
    logic [RC_W-1:0] m;
    unique case (s)
      4'd1:    m = RC_W'((1 << K_SH) / 1);
      4'd2:    m = RC_W'(((1 << K_SH) + 1) / 2);
      4'd3:    m = RC_W'(((1 << K_SH) + 2) / 3);
      4'd4:    m = RC_W'(((1 << K_SH) + 3) / 4);
      4'd5:    m = RC_W'(((1 << K_SH) + 4) / 5);
      4'd6:    m = RC_W'(((1 << K_SH) + 5) / 6);
      4'd7:    m = RC_W'(((1 << K_SH) + 6) / 7);
      4'd8:    m = RC_W'(((1 << K_SH) + 7) / 8);
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic span_t span_of(input logic [P_W-1:0] pos, input logic [P_W-1:0] len,
                                    input logic [1:0] k, input logic pad,
                                    input logic [spc2d_pkg::STEP_W-1:0] s);
    logic [P_W-1:0] plen, lo, hi, km1;
    span_t          sp;
    plen  = len + P_W'({pad, 1'b0});
    km1   = P_W'(k - 2'd1);
    lo    = (pos != '0) ? pos + P_W'(pad) : '0;
    hi    = (pos + 1'b1 < len) ? pos + P_W'(pad) : plen - 1'b1;
    if (lo < km1) begin
      lo = km1;
    end
    sp.ok = (plen >= P_W'(k)) && (hi >= lo);
    sp.nf = lo - km1 + P_W'(s) - 1'b1;
    sp.nl = hi - km1;
    return sp;
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_rows_q <= 2'd3;
      kernel_cols_q <= 2'd3;
      step_size_q   <= 4'd1;
      pad_enable_q  <= 1'b0;
      image_cols_q  <= 11'd1024;
      image_rows_q  <= 13'd1024;
      taps_first_q  <= '0;
      taps_second_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (spc2d_pkg::cfg_reg_e'(cfg_i.index))
        spc2d_pkg::REG_KERNEL_ROWS: kernel_rows_q <= cfg_i.data[1:0];
        spc2d_pkg::REG_KERNEL_COLS: kernel_cols_q <= cfg_i.data[1:0];
        spc2d_pkg::REG_STEP_SIZE:   step_size_q   <= cfg_i.data[3:0];
        spc2d_pkg::REG_PAD_ENABLE:  pad_enable_q  <= cfg_i.data[0];
        spc2d_pkg::REG_IMAGE_COLS:  image_cols_q  <= cfg_i.data[10:0];
        spc2d_pkg::REG_IMAGE_ROWS:  image_rows_q  <= cfg_i.data[12:0];
        spc2d_pkg::REG_TAPS_FIRST:  taps_first_q  <= cfg_i.data[59:0];
        spc2d_pkg::REG_TAPS_SECOND: taps_second_q <= cfg_i.data[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.kh = (kernel_rows_q == '0) ? 2'd1 :
              (kernel_rows_q > 2'(KERNEL_MAX)) ? 2'(KERNEL_MAX) : kernel_rows_q;
    geom.kw = (kernel_cols_q == '0) ? 2'd1 :
              (kernel_cols_q > 2'(KERNEL_MAX)) ? 2'(KERNEL_MAX) : kernel_cols_q;
    geom.step = (step_size_q == '0) ? 4'd1 :
                (step_size_q > 4'(spc2d_pkg::STEP_MAX)) ? 4'(spc2d_pkg::STEP_MAX)
                                                          : step_size_q;
    geom.pad = pad_enable_q;
    rows_p = (image_rows_q == '0) ? P_W'(1) :
             (image_rows_q > MAX_ROWS) ? P_W'(MAX_ROWS) : P_W'(image_rows_q);
    cols_p = (image_cols_q == '0) ? P_W'(1) :
             (image_cols_q > MAX_COLS) ? P_W'(MAX_COLS) : P_W'(image_cols_q);
  end

  for (genvar t = 0; t < TW; t++) begin : g_coef
    if (t < 5) begin : g_first
      assign coef[t] = taps_first_q[COEF_BITS*t +: COEF_BITS];
    end else begin : g_second
      assign coef[t] = taps_second_q[COEF_BITS*(t-5) +: COEF_BITS];
    end
  end

  assign inflight    = {1'b0, fill} + (CNT_W+1)'(s1_v_q) + (CNT_W+1)'(s2_v_q);
  assign pix_i.ready = (inflight < (CNT_W+1)'(DEPTH));
  assign acc         = pix_i.valid && pix_i.ready;

  always_comb begin
    c_t = pix_i.frame_start ? '0 : {1'b0, col_cnt_q};
    r_t = pix_i.frame_start ? '0 : {1'b0, row_cnt_q};
    if (P_W'(c_t) >= cols_p) begin
      c_t = '0;
      r_t = r_t + 1'b1;
    end
    if (P_W'(r_t) >= rows_p) begin
      r_t = '0;
    end
    ir  = r_t[RA_W-1:0];
    ic  = c_t[CA_W-1:0];
    c_n = {1'b0, ic} + 1'b1;
    r_n = {1'b0, ir};
    col_cnt_d = c_n[CA_W-1:0];
    row_cnt_d = ir;
    if (P_W'(c_n) >= cols_p) begin
      col_cnt_d = '0;
      r_n       = r_n + 1'b1;
      row_cnt_d = (P_W'(r_n) >= rows_p) ? '0 : r_n[RA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q <= line_mem[ic];
    end
    if (s1_v_q) begin
      line_mem[s1_ic_q] <= wr_word;
    end
  end

  always_comb begin
    word    = s1_fwd_q ? last_wr_q : rd_q;
    top_px  = s1_ir_q[0] ? word[15:8] : word[7:0];
    mid_px  = s1_ir_q[0] ? word[7:0] : word[15:8];
    wr_word = s1_ir_q[0] ? {s1_px_q, word[7:0]} : {word[15:8], s1_px_q};
    win_d   = win_q;
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]   = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = top_px;
    win_d[5] = mid_px;
    win_d[8] = s1_px_q;
  end

  assign rsp = span_of(P_W'(s1_ir_q), rows_p, geom.kh, geom.pad, geom.step);
  assign csp = span_of(P_W'(s1_ic_q), cols_p, geom.kw, geom.pad, geom.step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      win_q     <= '0;
    end else begin
      s1_v_q <= acc;
      s2_v_q <= s1_v_q;
      if (acc) begin
        row_cnt_q <= row_cnt_d;
        col_cnt_q <= col_cnt_d;
      end
      if (s1_v_q) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_px_q  <= pix_i.pixel;
      s1_ir_q  <= ir;
      s1_ic_q  <= ic;
      s1_fwd_q <= s1_v_q && (s1_ic_q == ic);
    end
    if (s1_v_q) begin
      last_wr_q <= wr_word;
      s2_win_q  <= win_d;
      s2_ir_q   <= P_W'(s1_ir_q);
      s2_ic_q   <= P_W'(s1_ic_q);
      s2_rs_q   <= rsp;
      s2_cs_q   <= csp;
      s2_end_q  <= (P_W'(s1_ir_q) + 1'b1 == rows_p) && (P_W'(s1_ic_q) + 1'b1 == cols_p);
    end
  end

  always_comb begin
    rcp  = recip(geom.step);
    mrf  = s2_rs_q.nf * rcp;
    mrl  = s2_rs_q.nl * rcp;
    mcf  = s2_cs_q.nf * rcp;
    mcl  = s2_cs_q.nl * rcp;
    rf   = mrf[K_SH +: P_W];
    rl   = mrl[K_SH +: P_W];
    cf   = mcf[K_SH +: P_W];
    cl   = mcl[K_SH +: P_W];
    have = s2_rs_q.ok && s2_cs_q.ok && (rf <= rl) && (cf <= cl);
  end

  spc2d_result_gen #(
    .P_W       (P_W),
    .COEF_BITS (COEF_BITS),
    .DEPTH     (DEPTH)
  ) u_result_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .rows_i      (rows_p),
    .cols_i      (cols_p),
    .coef_i      (coef),
    .push_i      (s2_v_q),
    .push_win_i  (s2_win_q),
    .push_rf_i   (rf),
    .push_rl_i   (rl),
    .push_cf_i   (cf),
    .push_cl_i   (cl),
    .push_ir_i   (s2_ir_q),
    .push_ic_i   (s2_ic_q),
    .push_have_i (have),
    .push_end_i  (s2_end_q),
    .fill_o      (fill),
    .res_o       (res_o)
  );

endmodule

@@ rtl/core/spc2d_checker.sv @@
// ----------------------------------------------------------------------------
// spc2d_checker
// Port-level checks on the result channel of the convolution block.
// ----------------------------------------------------------------------------
module spc2d_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic run_last_i,
  input logic frame_done_i,
  input logic [spc2d_pkg::SUM_W-1:0] sum_value_i
);

  // A stalled result keeps its beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sum_value_i))
    else $error("result beat dropped or changed while stalled");

  // The last result of an image is also the last result of its pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> run_last_i)
    else $error("frame_done without run_last");

  // Results of one pixel follow each other without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !run_last_i |=> out_valid_i)
    else $error("gap inside the results of one pixel");

endmodule

bind strided_padded_convolution_2d_top spc2d_checker u_spc2d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .run_last_i   (res_o.run_last),
  .frame_done_i (res_o.frame_done),
  .sum_value_i  (res_o.sum_value)
);

@@ dv/strided_padded_convolution_2d_top_test.sv @@
// ----------------------------------------------------------------------------
// strided_padded_convolution_2d_top_test
// Streams pixel frames through the convolution block under many geometries.
// Each accepted pixel beat updates a local window/line-store model, which
// queues the expected window sums. Every result beat is compared against
// the oldest queued sum, row, column and end flags.
// ----------------------------------------------------------------------------
module strided_padded_convolution_2d_top_test;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int LINE_LEN    = 1024;
  localparam int WIDE_COUNT  = 160;

  typedef logic [spc2d_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct {
    logic signed [spc2d_pkg::SUM_W-1:0] sum_value;
    logic [spc2d_pkg::ROW_W-1:0]        out_row;
    logic [spc2d_pkg::COL_W-1:0]        out_col;
    logic                               run_last;
    logic                               frame_done;
  } window_sum_t;

  typedef struct {
    logic [spc2d_pkg::PIX_W-1:0] pixel;
    logic                        frame_start;
  } pixel_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  spc2d_pix_if pix ();
  spc2d_res_if res ();
  spc2d_cfg_if cfg ();

  strided_padded_convolution_2d_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  logic [1:0]  k_rows = 2'd3;
  logic [1:0]  k_cols = 2'd3;
  logic [3:0]  stride = 4'd1;
  logic        pad_on = 1'b0;
  logic [10:0] img_cols = 11'd1024;
  logic [12:0] img_rows = 13'd1024;
  logic [59:0] taps_lo = '0;
  logic [47:0] taps_hi = '0;

  logic [spc2d_pkg::PIX_W-1:0] line_mem [2*LINE_LEN];
  logic [spc2d_pkg::PIX_W-1:0] win [9];
  int row_pos = 0;
  int col_pos = 0;

  window_sum_t expected_sums[$];
  pixel_beat_t pending_pixels[$];
  pixel_beat_t cur_beat;

  int  errors = 0;
  int  pixels_sent = 0;
  int  sums_seen = 0;
  int  phases_run = 0;
  int  cycles = 0;
  int  pix_gap = 0;
  int  res_stall = 0;
  bit  quiet = 1'b0;
  logic hold_off = 1'b0;

  initial begin
    forever #(CLK_PERIOD/2) clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic int coef(int t);
    logic [11:0] v;
    v = (t < 5) ? taps_lo[12*t +: 12] : taps_hi[12*(t-5) +: 12];
    return int'($signed(v));
  endfunction

  function automatic bit axis_span(input int pos, input int len, input int pd, input int k,
                                   input int s, output int first, output int last);
    int plen, outs, lo, hi;
    plen = len + 2*pd;
    first = 0;
    last = -1;
    if (plen < k) return 1'b0;
    outs = (plen - k) / s + 1;
    lo = (pos > 0) ? pos + pd : 0;
    hi = (pos < len - 1) ? pos + pd : plen - 1;
    if (lo < k - 1) lo = k - 1;
    if (hi < lo) return 1'b0;
    first = (lo - (k - 1) + s - 1) / s;
    last = (hi - (k - 1)) / s;
    if (last > outs - 1) last = outs - 1;
    return first <= last;
  endfunction

  function automatic void apply_reg(spc2d_pkg::cfg_reg_e idx, cfg_word_t d);
    case (idx)
      spc2d_pkg::REG_KERNEL_ROWS: k_rows = d[1:0];
      spc2d_pkg::REG_KERNEL_COLS: k_cols = d[1:0];
      spc2d_pkg::REG_STEP_SIZE:   stride = d[3:0];
      spc2d_pkg::REG_PAD_ENABLE:  pad_on = d[0];
      spc2d_pkg::REG_IMAGE_COLS:  img_cols = d[10:0];
      spc2d_pkg::REG_IMAGE_ROWS:  img_rows = d[12:0];
      spc2d_pkg::REG_TAPS_FIRST:  taps_lo = d[59:0];
      spc2d_pkg::REG_TAPS_SECOND: taps_hi = d[47:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_windows(pixel_beat_t b);
    int kh, kw, s, pd, cols, rows, ir, ic, n, rf, rl, cf, cl, y, x, dy, dx, acc;
    bit have_r, have_c;
    window_sum_t w;
    window_sum_t found[4];
    kh = (k_rows == 0) ? 1 : k_rows;
    kw = (k_cols == 0) ? 1 : k_cols;
    s = (stride == 0) ? 1 : ((stride > 8) ? 8 : stride);
    pd = pad_on;
    cols = (img_cols == 0) ? 1 : ((img_cols > LINE_LEN) ? LINE_LEN : img_cols);
    rows = (img_rows == 0) ? 1 : ((img_rows > 4096) ? 4096 : img_rows);
    n = 0;
    if (b.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= rows) row_pos = 0;
    ir = row_pos;
    ic = col_pos;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = line_mem[(ir & 1)*LINE_LEN + ic];
    win[5] = line_mem[((ir + 1) & 1)*LINE_LEN + ic];
    win[8] = b.pixel;
    line_mem[(ir & 1)*LINE_LEN + ic] = b.pixel;
    have_r = axis_span(ir, rows, pd, kh, s, rf, rl);
    have_c = axis_span(ic, cols, pd, kw, s, cf, cl);
    if (have_r && have_c) begin
      for (int r = rf; r <= rl; r++) begin
        for (int c = cf; c <= cl; c++) begin
          if (n < 4) begin
            acc = 0;
            for (int i = 0; i < kh; i++) begin
              for (int j = 0; j < kw; j++) begin
                y = r*s + i - pd;
                x = c*s + j - pd;
                dy = y - ir + 2;
                dx = x - ic + 2;
                if (y >= 0 && y < rows && x >= 0 && x < cols &&
                    dy >= 0 && dy <= 2 && dx >= 0 && dx <= 2)
                  acc += int'(win[dy*3 + dx]) * coef(i*kw + j);
              end
            end
            w.sum_value = acc[spc2d_pkg::SUM_W-1:0];
            w.out_row = r[spc2d_pkg::ROW_W-1:0];
            w.out_col = c[spc2d_pkg::COL_W-1:0];
            w.run_last = 1'b0;
            w.frame_done = 1'b0;
            found[n] = w;
            n++;
          end
        end
      end
    end
    if (n > 0) begin
      found[n-1].run_last = 1'b1;
      found[n-1].frame_done = (ir == rows - 1) && (ic == cols - 1);
    end
    for (int k = 0; k < n; k++) expected_sums.push_back(found[k]);
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) row_pos = 0;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix.valid && pix.ready) predict_windows(cur_beat);
      if (!pix.valid || pix.ready) begin
        if (pix_gap > 0) begin
          pix_gap--;
          pix.valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          cur_beat = pending_pixels.pop_front();
          pix.valid <= 1'b1;
          pix.pixel <= cur_beat.pixel;
          pix.frame_start <= cur_beat.frame_start;
          pixels_sent++;
          pix_gap = draw_gap();
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    window_sum_t e;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        sums_seen++;
        if (expected_sums.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: sum %0d row %0d col %0d",
                     res.sum_value, res.out_row, res.out_col);
        end else begin
          e = expected_sums.pop_front();
          if (res.sum_value !== e.sum_value || res.out_row !== e.out_row ||
              res.out_col !== e.out_col || res.run_last !== e.run_last ||
              res.frame_done !== e.frame_done) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp sum %0d row %0d col %0d last %b done %b",
                       e.sum_value, e.out_row, e.out_col, e.run_last, e.frame_done);
              $display("          got sum %0d row %0d col %0d last %b done %b",
                       res.sum_value, res.out_row, res.out_col, res.run_last,
                       res.frame_done);
            end
          end
        end
        res_stall = draw_gap();
      end
      if (hold_off) begin
        res.ready <= 1'b0;
      end else if (res_stall > 0) begin
        res_stall--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    wait (pixels_sent >= 200 && pending_pixels.size() >= 32);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic write_reg(spc2d_pkg::cfg_reg_e idx, cfg_word_t d);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk_i); while (!cfg.ready);
    apply_reg(idx, d);
    cfg.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_pixels.size() == 0 && !pix.valid && expected_sums.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Pixel style: 0 random, 1 all full scale, 2 all zero.
  task automatic run_phase(int kh, int kw, int s, int pd, int cols, int rows,
                           logic [59:0] tf, logic [47:0] ts, int count,
                           int style, bit noisy);
    int eff_cols, eff_rows, frame_len;
    pixel_beat_t b;
    write_reg(spc2d_pkg::REG_KERNEL_ROWS, cfg_word_t'(kh));
    write_reg(spc2d_pkg::REG_KERNEL_COLS, cfg_word_t'(kw));
    write_reg(spc2d_pkg::REG_STEP_SIZE, cfg_word_t'(s));
    write_reg(spc2d_pkg::REG_PAD_ENABLE, cfg_word_t'(pd));
    write_reg(spc2d_pkg::REG_IMAGE_COLS, cfg_word_t'(cols));
    write_reg(spc2d_pkg::REG_IMAGE_ROWS, cfg_word_t'(rows));
    write_reg(spc2d_pkg::REG_TAPS_FIRST, cfg_word_t'(tf));
    write_reg(spc2d_pkg::REG_TAPS_SECOND, cfg_word_t'(ts));
    eff_cols = (cols[10:0] == 0) ? 1 : ((cols[10:0] > LINE_LEN) ? LINE_LEN : cols[10:0]);
    eff_rows = (rows[12:0] == 0) ? 1 : ((rows[12:0] > 4096) ? 4096 : rows[12:0]);
    frame_len = eff_cols * eff_rows;
    for (int i = 0; i < count; i++) begin
      b.pixel = (style == 1) ? 8'hFF : ((style == 2) ? 8'h00 : 8'($urandom));
      if (i == 0) b.frame_start = 1'b1;
      else if (i % frame_len == 0) b.frame_start = $urandom_range(0, 1);
      else b.frame_start = noisy && ($urandom_range(0, 59) == 0);
      pending_pixels.push_back(b);
    end
    phases_run++;
    wait_idle();
  endtask

  initial begin
    int kh, kw, s, pd, cols, rows, frames, count;
    bit wide_done;
    pix.valid = 1'b0;
    pix.pixel = '0;
    pix.frame_start = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = spc2d_pkg::REG_KERNEL_ROWS;
    cfg.data = '0;
    wide_done = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    quiet = 1'b1;
    run_phase(3, 3, 1, 0, 4, 3, {5{12'h7FF}}, {4{12'h7FF}}, 12, 1, 1'b0);
    quiet = 1'b0;
    run_phase(3, 3, 1, 1, 3, 2, {5{12'h800}}, {4{12'h800}}, 6, 1, 1'b0);
    run_phase(1, 1, 1, 1, 1, 1, {5{12'h800}}, {4{12'h800}}, 1, 1, 1'b0);
    run_phase(2, 3, 8, 0, 2, 2, 60'h0, 48'h0, 4, 2, 1'b0);
    run_phase(0, 0, 15, 0, 0, 0, {5{12'h100}}, {4{12'h100}}, 2, 0, 1'b0);

    while (pixels_sent < 460) begin
      quiet = ($urandom_range(0, 4) == 0);
      kh = $urandom_range(0, 3);
      kw = $urandom_range(0, 3);
      s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
      pd = $urandom_range(0, 1);
      cols = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 9);
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 7);
      frames = $urandom_range(1, 3);
      count = ((cols == 0) ? 1 : cols) * ((rows == 0) ? 1 : rows) * frames;
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      if (!wide_done && pixels_sent > 250) begin
        cols = 2047;
        rows = 1;
        s = 8;
        count = WIDE_COUNT;
        wide_done = 1'b1;
      end else if ($urandom_range(0, 11) == 0) begin
        rows = ($urandom_range(0, 1) == 0) ? 4096 : 8191;
        count = $urandom_range(5, 30);
      end
      run_phase(kh, kw, s, pd, cols, rows, 60'({$urandom, $urandom}),
                48'({$urandom, $urandom}),
                count, ($urandom_range(0, 9) == 0) ? 1 : 0, $urandom_range(0, 1));
    end

    wait_idle();
    errors += expected_sums.size();
    $display("covered %0d pixel beats in %0d configuration phases, %0d result beats",
             pixels_sent, phases_run, sums_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/spc2d_pkg.sv
rtl/core/spc2d_if.sv
rtl/core/spc2d_result_gen.sv
rtl/core/strided_padded_convolution_2d_top.sv
rtl/core/spc2d_checker.sv
dv/strided_padded_convolution_2d_top_test.sv
